// ===== sv/tccs_pkg.sv =====
// Shared types, codes and constants for the text console cursor/scroll engine.
package tccs_pkg;

  // Default screen geometry
  localparam int SCREEN_COLUMNS_DEF = 80;
  localparam int SCREEN_ROWS_DEF    = 25;

  // Field widths fixed by the interface
  localparam int KIND_W     = 2;
  localparam int CHAR_W     = 8;
  localparam int COLOUR_W   = 4;
  localparam int COORD_IN_W = 8;
  localparam int ADDR_IN_W  = 11;
  localparam int COL_OUT_W  = 7;
  localparam int ROW_OUT_W  = 5;
  localparam int LOC_OUT_W  = 11;
  localparam int CELL_W     = 16;
  localparam int CFG_IDX_W  = 1;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SET   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 1'd1;

  // Character codes and cell words
  localparam logic [CHAR_W-1:0]   CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0]   CH_LINEFEED  = 8'h0A;
  localparam logic [CHAR_W-1:0]   CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0]   CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0]   CH_LAST      = 8'h7F;
  localparam logic [COLOUR_W-1:0] COLOUR_WHITE = 4'hF;
  localparam logic [COLOUR_W-1:0] BG_RESET     = 4'h0;
  localparam logic [COLOUR_W-1:0] FG_RESET     = 4'hF;
  localparam logic [CELL_W-1:0]   BLANK_WORD   = 16'h0F20;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [CHAR_W-1:0]     char_code;
    logic [COLOUR_W-1:0]   clear_background;
    logic [COORD_IN_W-1:0] column_in;
    logic [COORD_IN_W-1:0] row_in;
    logic [ADDR_IN_W-1:0]  cell_address;
  } in_item_t;

  typedef struct packed {
    logic [COL_OUT_W-1:0] cursor_column;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [LOC_OUT_W-1:0] cursor_location;
    logic                 scrolled;
    logic [CELL_W-1:0]    cell_data;
  } out_item_t;

  // Colour settings handed to the sequencer
  typedef struct packed {
    logic [COLOUR_W-1:0] background;
    logic [COLOUR_W-1:0] foreground;
  } colours_t;

endpackage

// ===== sv/tccs_cell_mem.sv =====
// Cell store: one write port, one read port, registered read data.
module tccs_cell_mem #(
  parameter int DEPTH = tccs_pkg::SCREEN_COLUMNS_DEF * tccs_pkg::SCREEN_ROWS_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [ADDR_W-1:0]           waddr,
  input  logic [tccs_pkg::CELL_W-1:0] wdata,
  input  logic                        re,
  input  logic [ADDR_W-1:0]           raddr,
  output logic [tccs_pkg::CELL_W-1:0] rdata
);

  logic [tccs_pkg::CELL_W-1:0] mem_r [DEPTH];
  logic [tccs_pkg::CELL_W-1:0] rdata_r;

  // Write and read in the same clocked block
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/tccs_ctrl.sv =====
// Sequencer: cursor registers, put/clear/set/read handling, scroll copy and fill sweeps.
module tccs_ctrl #(
  parameter int SCREEN_COLUMNS = tccs_pkg::SCREEN_COLUMNS_DEF,
  parameter int SCREEN_ROWS    = tccs_pkg::SCREEN_ROWS_DEF,
  localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS,
  localparam int ADDR_W     = $clog2(CELL_COUNT)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  tccs_pkg::in_item_t          in_item,
  output logic                        in_stall,
  input  tccs_pkg::colours_t          colours,
  output logic                        res_valid,
  output tccs_pkg::out_item_t         res_item,
  input  logic                        res_take,
  output logic                        mem_we,
  output logic [ADDR_W-1:0]           mem_waddr,
  output logic [tccs_pkg::CELL_W-1:0] mem_wdata,
  output logic                        mem_re,
  output logic [ADDR_W-1:0]           mem_raddr,
  input  logic [tccs_pkg::CELL_W-1:0] mem_rdata
);

  localparam int COL_W  = $clog2(SCREEN_COLUMNS);
  localparam int ROW_W  = $clog2(SCREEN_ROWS);
  localparam int COPY_N = CELL_COUNT - SCREEN_COLUMNS;

  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(SCREEN_COLUMNS - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(SCREEN_ROWS - 1);
  localparam logic [ADDR_W-1:0] CNT_LAST  = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(COPY_N - 1);
  localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(COPY_N);
  localparam logic [ADDR_W-1:0] ROW_SPAN  = ADDR_W'(SCREEN_COLUMNS);

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] S_INIT   = 3'd0;
  localparam logic [ST_W-1:0] S_IDLE   = 3'd1;
  localparam logic [ST_W-1:0] S_SCROLL = 3'd2;
  localparam logic [ST_W-1:0] S_FILL   = 3'd3;
  localparam logic [ST_W-1:0] S_RDWAIT = 3'd4;
  localparam logic [ST_W-1:0] S_DONE   = 3'd5;

  logic [ST_W-1:0]             state_r, state_nxt;
  logic [COL_W-1:0]            col_r, col_nxt;
  logic [ROW_W-1:0]            row_r, row_nxt;
  logic [ADDR_W-1:0]           cnt_r, cnt_nxt;
  logic                        pend_r, pend_nxt;
  logic [ADDR_W-1:0]           pend_addr_r, pend_addr_nxt;
  logic [tccs_pkg::CELL_W-1:0] fill_word_r, fill_word_nxt;
  logic                        scrolled_r, scrolled_nxt;
  logic [tccs_pkg::CELL_W-1:0] data_r, data_nxt;
  logic                        oob_r, oob_nxt;

  logic [ADDR_W-1:0] cur_addr;
  logic              printable;
  logic [COL_W-1:0]  put_col;
  logic [ROW_W-1:0]  put_row;
  logic              row_inc;
  logic              put_scroll;
  logic [COL_W-1:0]  set_col;
  logic [ROW_W-1:0]  set_row;
  logic              rd_oob;

  // Cursor cell index, shared by put writes and the location report
  assign cur_addr = ADDR_W'(row_r) * ROW_SPAN + ADDR_W'(col_r);

  assign printable = (in_item.char_code >= tccs_pkg::CH_SPACE) &&
                     (in_item.char_code <= tccs_pkg::CH_LAST);

  // Cursor motion of a put item
  always_comb begin
    put_col = col_r;
    row_inc = 1'b0;
    case (in_item.char_code)
      tccs_pkg::CH_BACKSPACE: begin
        if (col_r != '0) begin
          put_col = col_r - 1'b1;
        end
      end
      tccs_pkg::CH_RETURN: begin
        put_col = '0;
      end
      tccs_pkg::CH_LINEFEED: begin
        put_col = '0;
        row_inc = 1'b1;
      end
      default: begin
        if (printable) begin
          if (col_r == COL_LAST) begin
            put_col = '0;
            row_inc = 1'b1;
          end else begin
            put_col = col_r + 1'b1;
          end
        end
      end
    endcase
    put_scroll = row_inc && (row_r == ROW_LAST);
    put_row    = (row_inc && !put_scroll) ? row_r + 1'b1 : row_r;
  end

  // Clamp a set-cursor request to the screen
  assign set_col = (int'(in_item.column_in) > SCREEN_COLUMNS - 1) ?
                   COL_LAST : COL_W'(in_item.column_in);
  assign set_row = (int'(in_item.row_in) > SCREEN_ROWS - 1) ?
                   ROW_LAST : ROW_W'(in_item.row_in);
  assign rd_oob  = int'(in_item.cell_address) >= CELL_COUNT;

  assign in_stall = (state_r != S_IDLE);

  // Next state, memory port control
  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    fill_word_nxt = fill_word_r;
    scrolled_nxt  = scrolled_r;
    data_nxt      = data_r;
    oob_nxt       = oob_r;
    mem_we        = 1'b0;
    mem_waddr     = cnt_r;
    mem_wdata     = fill_word_r;
    mem_re        = 1'b0;
    mem_raddr     = cnt_r;
    res_valid     = 1'b0;
    case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          scrolled_nxt = 1'b0;
          data_nxt     = '0;
          cnt_nxt      = '0;
          case (in_item.kind)
            tccs_pkg::KIND_PUT: begin
              mem_we       = printable;
              mem_waddr    = cur_addr;
              mem_wdata    = {colours.background, colours.foreground, in_item.char_code};
              col_nxt      = put_col;
              row_nxt      = put_row;
              scrolled_nxt = put_scroll;
              state_nxt    = put_scroll ? S_SCROLL : S_DONE;
            end
            tccs_pkg::KIND_CLEAR: begin
              fill_word_nxt = {in_item.clear_background, tccs_pkg::COLOUR_WHITE,
                               tccs_pkg::CH_SPACE};
              col_nxt       = '0;
              row_nxt       = '0;
              state_nxt     = S_FILL;
            end
            tccs_pkg::KIND_SET: begin
              col_nxt   = set_col;
              row_nxt   = set_row;
              state_nxt = S_DONE;
            end
            default: begin
              mem_re    = 1'b1;
              mem_raddr = rd_oob ? '0 : ADDR_W'(in_item.cell_address);
              oob_nxt   = rd_oob;
              state_nxt = S_RDWAIT;
            end
          endcase
        end
      end
      S_SCROLL: begin
        // Read one row ahead, write the previous read back one row up
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr_r;
          mem_wdata = mem_rdata;
        end
        mem_re        = 1'b1;
        mem_raddr     = cnt_r + ROW_SPAN;
        pend_nxt      = 1'b1;
        pend_addr_nxt = cnt_r;
        if (cnt_r == COPY_LAST) begin
          cnt_nxt       = COPY_END;
          fill_word_nxt = tccs_pkg::BLANK_WORD;
          state_nxt     = S_FILL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FILL: begin
        // Drain the last copy write, then sweep the fill word
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr_r;
          mem_wdata = mem_rdata;
        end else begin
          mem_we = 1'b1;
          if (cnt_r == CNT_LAST) begin
            state_nxt = S_DONE;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      S_RDWAIT: begin
        data_nxt  = oob_r ? '0 : mem_rdata;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result word seen by the output register
  always_comb begin
    res_item.cursor_column   = tccs_pkg::COL_OUT_W'(col_r);
    res_item.cursor_row      = tccs_pkg::ROW_OUT_W'(row_r);
    res_item.cursor_location = tccs_pkg::LOC_OUT_W'(cur_addr);
    res_item.scrolled        = scrolled_r;
    res_item.cell_data       = data_r;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      col_r   <= '0;
      row_r   <= '0;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    fill_word_r <= fill_word_nxt;
    scrolled_r  <= scrolled_nxt;
    data_r      <= data_nxt;
    oob_r       <= oob_nxt;
  end

endmodule

// ===== sv/text_console_cursor_scroll.sv =====
// Top level of the text console engine: config registers, output register, cell store.
//
//   channel | handshake          | payload
//   --------+--------------------+---------------------------------
//   in      | in_valid/in_stall  | in_item   (tccs_pkg::in_item_t)
//   out     | out_valid/out_stall| out_item  (tccs_pkg::out_item_t)
//   cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Put without scroll and set cursor pass from idle straight to the result state, a read
// waits for the registered read data first; a clear sweeps every cell once and a scroll
// copies and refills through the single write port, one cell a cycle.
// After reset a clearing pass zeroes every cell of the store;
// in_stall stays high meanwhile, config writes are taken at any time.
// The output register holds a result while out_stall is high; one more item can be taken behind it.
module text_console_cursor_scroll #(
  parameter int SCREEN_COLUMNS = tccs_pkg::SCREEN_COLUMNS_DEF,
  parameter int SCREEN_ROWS    = tccs_pkg::SCREEN_ROWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  tccs_pkg::in_item_t             in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output tccs_pkg::out_item_t            out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tccs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tccs_pkg::COLOUR_W-1:0]  cfg_data
);

  localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  logic [tccs_pkg::COLOUR_W-1:0] bg_r;
  logic [tccs_pkg::COLOUR_W-1:0] fg_r;
  tccs_pkg::colours_t            colours;

  logic                res_valid;
  logic                res_take;
  tccs_pkg::out_item_t res_item;
  logic                out_valid_r;
  tccs_pkg::out_item_t out_item_r;

  logic                        mem_we;
  logic [ADDR_W-1:0]           mem_waddr;
  logic [tccs_pkg::CELL_W-1:0] mem_wdata;
  logic                        mem_re;
  logic [ADDR_W-1:0]           mem_raddr;
  logic [tccs_pkg::CELL_W-1:0] mem_rdata;

  // Colour registers, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_r <= tccs_pkg::BG_RESET;
      fg_r <= tccs_pkg::FG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tccs_pkg::CFG_BACKGROUND: bg_r <= cfg_data;
        tccs_pkg::CFG_FOREGROUND: fg_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign colours.background = bg_r;
  assign colours.foreground = fg_r;

  tccs_ctrl #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .colours   (colours),
    .res_valid (res_valid),
    .res_item  (res_item),
    .res_take  (res_take),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  tccs_cell_mem #(
    .DEPTH (CELL_COUNT)
  ) u_cell_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Load the output register when it is empty or being drained
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_item_r <= res_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // An accepted item always leaves the sequencer busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted without the sequencer going busy");

  // A finished result waits unchanged until the output register takes it
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_take) |=> (res_valid && $stable(res_item)))
    else $error("pending result dropped or changed");

  // Reported cursor row stays on the screen
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_item.cursor_row) < SCREEN_ROWS))
    else $error("cursor row off screen");

  // A scroll leaves the cursor on the last row
  a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.scrolled) |->
      (out_item.cursor_row == tccs_pkg::ROW_OUT_W'(SCREEN_ROWS - 1)))
    else $error("scroll reported off the last row");

endmodule

// ===== test/text_console_cursor_scroll_tb.sv =====
// Self-checking testbench for the text console engine: cursor, scroll, clear and cell reads.
`timescale 1ns / 1ps

module text_console_cursor_scroll_tb;
  import tccs_pkg::*;

  localparam int COLS        = SCREEN_COLUMNS_DEF;
  localparam int ROWS        = SCREEN_ROWS_DEF;
  localparam int CELLS       = COLS * ROWS;
  localparam int DIR_ROWS    = 25;
  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 130;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int TAIL_CYCLES = CELLS + 100;

  // Per-phase idle profile and colours; 16 picks a random colour
  localparam int SEND_IDLE [PHASES] = '{0, 81, 0, 10, 0};
  localparam int RECV_STALL[PHASES] = '{0, 0, 81, 10, 0};
  localparam int PHASE_BG  [PHASES] = '{15, 0, 15, 16, 7};
  localparam int PHASE_FG  [PHASES] = '{0, 0, 15, 16, 8};
  localparam int PRESSURE_PHASE     = 4;

  // Cursor reports that can be written down directly
  localparam out_item_t RES_HOME   = '{7'd0, 5'd0, 11'd0, 1'b0, 16'h0000};
  localparam out_item_t RES_CORNER = '{7'd79, 5'd24, 11'd1999, 1'b0, 16'h0000};

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_item = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COLOUR_W-1:0]  cfg_data = '0;

  // Shadow of the console state
  logic [CELL_W-1:0]   screen_shadow [CELLS];
  int                  cur_col;
  int                  cur_row;
  logic [COLOUR_W-1:0] bg_colour;
  logic [COLOUR_W-1:0] fg_colour;

  out_item_t pending_reports[$];
  dir_row_t  dir_rows[DIR_ROWS];

  int errors = 0;
  int items_sent = 0;
  int reports_seen = 0;
  int scroll_count = 0;
  int clear_count = 0;
  int colour_writes = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;
  bit pressure_go = 1'b0;
  bit holding = 1'b0;

  text_console_cursor_scroll u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Apply one item to the shadow state and return the cursor report it causes
  function automatic out_item_t apply_console_item(input in_item_t it);
    out_item_t          rep;
    logic [CELL_W-1:0]  fill;
    rep = '0;
    case (it.kind)
      KIND_PUT: begin
        if (it.char_code == CH_BACKSPACE) begin
          if (cur_col > 0) cur_col--;
        end else if (it.char_code == CH_RETURN) begin
          cur_col = 0;
        end else if (it.char_code == CH_LINEFEED) begin
          cur_col = 0;
          cur_row++;
        end else if (it.char_code >= CH_SPACE && it.char_code <= CH_LAST) begin
          screen_shadow[cur_row * COLS + cur_col] = {bg_colour, fg_colour, it.char_code};
          cur_col++;
        end
        // wrap at the right edge
        if (cur_col >= COLS) begin
          cur_col = 0;
          cur_row++;
        end
        // scroll up one row and blank the bottom
        if (cur_row >= ROWS) begin
          for (int i = 0; i < CELLS - COLS; i++) screen_shadow[i] = screen_shadow[i + COLS];
          for (int i = CELLS - COLS; i < CELLS; i++) screen_shadow[i] = BLANK_WORD;
          cur_row = ROWS - 1;
          rep.scrolled = 1'b1;
        end
      end
      KIND_CLEAR: begin
        fill = {it.clear_background, COLOUR_WHITE, CH_SPACE};
        for (int i = 0; i < CELLS; i++) screen_shadow[i] = fill;
        cur_col = 0;
        cur_row = 0;
      end
      KIND_SET: begin
        cur_col = (it.column_in > COLS - 1) ? COLS - 1 : int'(it.column_in);
        cur_row = (it.row_in > ROWS - 1) ? ROWS - 1 : int'(it.row_in);
      end
      default: begin
        if (it.cell_address < CELLS) rep.cell_data = screen_shadow[it.cell_address];
      end
    endcase
    rep.cursor_column   = COL_OUT_W'(cur_col);
    rep.cursor_row      = ROW_OUT_W'(cur_row);
    rep.cursor_location = LOC_OUT_W'(cur_row * COLS + cur_col);
    return rep;
  endfunction

  function automatic in_item_t mk_item(input logic [KIND_W-1:0] kind,
                                       input logic [CHAR_W-1:0] ch,
                                       input logic [COLOUR_W-1:0] bg,
                                       input logic [COORD_IN_W-1:0] col,
                                       input logic [COORD_IN_W-1:0] row,
                                       input logic [ADDR_IN_W-1:0] addr);
    in_item_t it;
    it.kind             = kind;
    it.char_code        = ch;
    it.clear_background = bg;
    it.column_in        = col;
    it.row_in           = row;
    it.cell_address     = addr;
    return it;
  endfunction

  // Mostly printable text, with controls, cursor moves, reads, noise bytes and rare clears
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned pick;
    it.kind             = KIND_PUT;
    it.char_code        = CHAR_W'($urandom_range(255));
    it.clear_background = COLOUR_W'($urandom_range(15));
    it.column_in        = COORD_IN_W'($urandom_range(255));
    it.row_in           = COORD_IN_W'($urandom_range(255));
    it.cell_address     = ADDR_IN_W'($urandom_range(2047));
    pick = $urandom_range(99);
    if (pick < 50) begin
      it.char_code = CHAR_W'($urandom_range(CH_LAST, CH_SPACE));
    end else if (pick < 65) begin
      case ($urandom_range(2))
        0:       it.char_code = CH_BACKSPACE;
        1:       it.char_code = CH_RETURN;
        default: it.char_code = CH_LINEFEED;
      endcase
    end else if (pick < 73) begin
      // keep the raw byte: high codes and stray controls
    end else if (pick < 85) begin
      it.kind = KIND_SET;
      if ($urandom_range(1) == 0) begin
        it.column_in = COORD_IN_W'($urandom_range(COLS - 1));
        it.row_in    = COORD_IN_W'($urandom_range(ROWS - 1));
      end
    end else if (pick < 98) begin
      it.kind = KIND_READ;
      if ($urandom_range(9) != 0) it.cell_address = ADDR_IN_W'($urandom_range(CELLS - 1));
    end else begin
      it.kind = KIND_CLEAR;
    end
    return it;
  endfunction

  // Offer one item, hold it until taken, then record its expected report
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t pred;
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    pred = apply_console_item(it);
    pending_reports.push_back(typed ? want : pred);
    items_sent++;
    if (pred.scrolled) scroll_count++;
    if (it.kind == KIND_CLEAR) clear_count++;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Write both colour registers back to back
  task automatic set_colours(input logic [COLOUR_W-1:0] bg, input logic [COLOUR_W-1:0] fg);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_BACKGROUND;
    cfg_data  <= bg;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    bg_colour = bg;
    cfg_index <= CFG_FOREGROUND;
    cfg_data  <= fg;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    fg_colour = fg;
    cfg_valid <= 1'b0;
    colour_writes += 2;
  endtask

  // Drop valid and wait for every outstanding report
  task automatic drain_reports();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic flag_field(input string field, input logic [CELL_W-1:0] want,
                            input logic [CELL_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, field, want, got);
      errors++;
    end
  endtask

  // Receiver: random stall, or a long hold-off when asked
  always @(posedge clk) begin
    if (holding) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    wait (pressure_go);
    @(posedge clk);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding <= 1'b0;
  end

  // Compare each taken report with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: report with no item pending: expected none, got %p", $time, out_item);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        reports_seen++;
        flag_field("cursor_column", CELL_W'(want.cursor_column), CELL_W'(out_item.cursor_column));
        flag_field("cursor_row", CELL_W'(want.cursor_row), CELL_W'(out_item.cursor_row));
        flag_field("cursor_location", CELL_W'(want.cursor_location),
                   CELL_W'(out_item.cursor_location));
        flag_field("scrolled", CELL_W'(want.scrolled), CELL_W'(out_item.scrolled));
        flag_field("cell_data", want.cell_data, out_item.cell_data);
      end
    end
  end

  // Hang guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d reports pending", cycle_count,
               pending_reports.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int bg;
    int fg;

    // Directed rows: reset contents, byte extremes, controls, clamping, scroll, clear
    dir_rows[0]  = '{mk_item(KIND_READ, 8'h00, 4'h0, 8'd0, 8'd0, 11'd0), 1'b1, RES_HOME};
    dir_rows[1]  = '{mk_item(KIND_READ, 8'h00, 4'h0, 8'd0, 8'd0, 11'd2047), 1'b1, RES_HOME};
    dir_rows[2]  = '{mk_item(KIND_READ, 8'h00, 4'h0, 8'd0, 8'd0, 11'd1999), 1'b1, RES_HOME};
    dir_rows[3]  = '{mk_item(KIND_PUT, 8'h41, 4'h0, 8'd0, 8'd0, 11'd0), 1'b0, '0};
    dir_rows[4]  = '{mk_item(KIND_PUT, 8'h80, 4'h0, 8'd0, 8'd0, 11'd0), 1'b0, '0};
    dir_rows[5]  = '{mk_item(KIND_PUT, 8'hFF, 4'h0, 8'd0, 8'd0, 11'd0), 1'b0, '0};
    dir_rows[6]  = '{mk_item(KIND_PUT, 8'h01, 4'h0, 8'd0, 8'd0, 11'd0), 1'b0, '0};
    dir_rows[7]  = '{mk_item(KIND_PUT, CH_BACKSPACE, 4'h0, 8'd0, 8'd0, 11'd0), 1'b0, '0};
    dir_rows[8]  = '{mk_item(KIND_PUT, CH_BACKSPACE, 4'h0, 8'd0, 8'd0, 11'd0), 1'b0, '0};
    dir_rows[9]  = '{mk_item(KIND_PUT, CH_LAST, 4'h0, 8'd0, 8'd0, 11'd0), 1'b0, '0};
    dir_rows[10] = '{mk_item(KIND_PUT, CH_SPACE, 4'h0, 8'd0, 8'd0, 11'd0), 1'b0, '0};
    dir_rows[11] = '{mk_item(KIND_PUT, CH_RETURN, 4'h0, 8'd0, 8'd0, 11'd0), 1'b0, '0};
    dir_rows[12] = '{mk_item(KIND_PUT, CH_LINEFEED, 4'h0, 8'd0, 8'd0, 11'd0), 1'b0, '0};
    dir_rows[13] = '{mk_item(KIND_SET, 8'h00, 4'h0, 8'd255, 8'd255, 11'd0), 1'b1, RES_CORNER};
    dir_rows[14] = '{mk_item(KIND_PUT, 8'h5A, 4'h0, 8'd0, 8'd0, 11'd0), 1'b0, '0};
    dir_rows[15] = '{mk_item(KIND_READ, 8'h00, 4'h0, 8'd0, 8'd0, 11'd1920), 1'b0, '0};
    dir_rows[16] = '{mk_item(KIND_READ, 8'h00, 4'h0, 8'd0, 8'd0, 11'd1919), 1'b0, '0};
    dir_rows[17] = '{mk_item(KIND_SET, 8'h00, 4'h0, 8'd0, 8'd0, 11'd0), 1'b1, RES_HOME};
    dir_rows[18] = '{mk_item(KIND_SET, 8'h00, 4'h0, 8'd79, 8'd24, 11'd0), 1'b1, RES_CORNER};
    dir_rows[19] = '{mk_item(KIND_PUT, CH_LINEFEED, 4'h0, 8'd0, 8'd0, 11'd0), 1'b0, '0};
    dir_rows[20] = '{mk_item(KIND_CLEAR, 8'h00, 4'hF, 8'd0, 8'd0, 11'd0), 1'b1, RES_HOME};
    dir_rows[21] = '{mk_item(KIND_READ, 8'h00, 4'h0, 8'd0, 8'd0, 11'd0), 1'b0, '0};
    dir_rows[22] = '{mk_item(KIND_READ, 8'h00, 4'h0, 8'd0, 8'd0, 11'd1999), 1'b0, '0};
    dir_rows[23] = '{mk_item(KIND_CLEAR, 8'h00, 4'h0, 8'd0, 8'd0, 11'd0), 1'b1, RES_HOME};
    dir_rows[24] = '{mk_item(KIND_SET, 8'h00, 4'h0, 8'd80, 8'd25, 11'd0), 1'b1, RES_CORNER};

    // Shadow state after reset
    for (int i = 0; i < CELLS; i++) screen_shadow[i] = '0;
    cur_col   = 0;
    cur_row   = 0;
    bg_colour = BG_RESET;
    fg_colour = FG_RESET;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) send_item(dir_rows[r].item, dir_rows[r].typed,
                                                 dir_rows[r].want);
    // out-of-range read with the cursor parked in the corner
    send_item(mk_item(KIND_READ, 8'h00, 4'h0, 8'd0, 8'd0, 11'd2000), 1'b1, RES_CORNER);
    drain_reports();

    // Random phases, each with its own colours and idle profile
    for (int p = 0; p < PHASES; p++) begin
      bg = (PHASE_BG[p] == 16) ? $urandom_range(15) : PHASE_BG[p];
      fg = (PHASE_FG[p] == 16) ? $urandom_range(15) : PHASE_FG[p];
      set_colours(COLOUR_W'(bg), COLOUR_W'(fg));
      send_idle_pct = SEND_IDLE[p];
      recv_stall_pct <= RECV_STALL[p];
      if (p == PRESSURE_PHASE) pressure_go <= 1'b1;
      repeat (PHASE_ITEMS) send_item(random_item(), 1'b0, '0);
      drain_reports();
    end

    // Watch for stray reports after the last one
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d items (%0d directed, rest random) under five idle/stall profiles.",
             items_sent, DIR_ROWS + 1);
    $display("Checked %0d reports: %0d scrolls, %0d clears, %0d colour register writes.",
             reports_seen, scroll_count, clear_count, colour_writes);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
